// ----- rtl/tcce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared geometry, codes, types and tables of the text console cell engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	// Screen geometry
	localparam int COLS     = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 2;
	localparam int CELLS    = COLS * ROWS;

	localparam int COL_W = $clog2(COLS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int POS_W = $clog2(CELLS);

	// Port field widths
	localparam int OPCODE_W   = 2;
	localparam int CHAR_W     = 8;
	localparam int IN_COL_W   = 7;
	localparam int IN_ROW_W   = 5;
	localparam int IDX_W      = 11;
	localparam int CELL_W     = 16;
	localparam int COLOR_W    = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [COL_W-1:0]   col_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [POS_W:0]     pos_x_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [CELL_W-1:0]  cell_t;
	typedef logic [QPTR_W:0]    qcnt_t;

	localparam pos_x_t CELLS_X      = pos_x_t'(CELLS);
	localparam pos_t   LAST_ROW_POS = pos_t'((ROWS - 1) * COLS);
	localparam col_t   LAST_COL     = col_t'(COLS - 1);
	localparam row_t   LAST_ROW     = row_t'(ROWS - 1);
	localparam qcnt_t  QCNT_FULL    = qcnt_t'(QUEUE_DEPTH);

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_MOVE  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd3;

	// Control characters
	localparam char_t CH_SPACE     = 8'h20;
	localparam char_t CH_BACKSPACE = 8'h08;
	localparam char_t CH_TAB       = 8'h09;
	localparam char_t CH_NEWLINE   = 8'h0A;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd1;

	localparam color_t RESET_FG   = 4'hF;
	localparam color_t RESET_BG   = 4'h0;
	localparam cell_t  RESET_CELL = {RESET_BG, RESET_FG, CH_SPACE};

	// Column is a tab stop
	function automatic logic [COLS-1:0] build_tab_hit();
		logic [COLS-1:0] v;
		for (int i = 0; i < COLS; i++) begin
			v[i] = ((i % TAB_STOP) == 0);
		end
		return v;
	endfunction

	localparam logic [COLS-1:0] TAB_HIT = build_tab_hit();

	typedef enum logic [2:0] {
		K_PRINT,
		K_BS,
		K_NL,
		K_TAB,
		K_CLEAR,
		K_MOVE,
		K_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		char_t     ch;
		logic      eow;
		col_t      col;
		row_t      row;
		pos_t      ridx;
		logic      rd_ok;
	} cmd_t;

endpackage
`default_nettype wire

// ----- rtl/tcce_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ifs
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface tcce_in_if;
	logic                                valid;
	logic                                ready;
	logic [tcce_pkg::OPCODE_W-1:0]       opcode;
	logic [tcce_pkg::CHAR_W-1:0]         char_code;
	logic [tcce_pkg::IN_COL_W-1:0]       col;
	logic [tcce_pkg::IN_ROW_W-1:0]       row;
	logic                                end_of_write;
	logic [tcce_pkg::IDX_W-1:0]          cell_index;

	modport source (
		output valid, opcode, char_code, col, row, end_of_write, cell_index,
		input  ready
	);
	modport sink (
		input  valid, opcode, char_code, col, row, end_of_write, cell_index,
		output ready
	);
endinterface

interface tcce_out_if;
	logic                                valid;
	logic                                ready;
	logic [tcce_pkg::IN_COL_W-1:0]       cursor_col;
	logic [tcce_pkg::IN_ROW_W-1:0]       cursor_row;
	logic [tcce_pkg::IDX_W-1:0]          hw_cursor_pos;
	logic [tcce_pkg::CELL_W-1:0]         read_cell;

	modport source (
		output valid, cursor_col, cursor_row, hw_cursor_pos, read_cell,
		input  ready
	);
	modport sink (
		input  valid, cursor_col, cursor_row, hw_cursor_pos, read_cell,
		output ready
	);
endinterface
`default_nettype wire

// ----- rtl/tcce_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_front
// Accepts command beats, decodes them into internal commands, pushes them.
// ----------------------------------------------------------------------------
module tcce_front (
	tcce_in_if.sink          in_ch,
	input  logic             q_full,
	input  logic             init_busy,
	output logic             push,
	output tcce_pkg::cmd_t   cmd
);

	assign in_ch.ready = !q_full && !init_busy;
	assign push        = in_ch.valid && in_ch.ready;

	always_comb begin
		cmd       = '0;
		cmd.kind  = tcce_pkg::K_PRINT;
		cmd.ch    = in_ch.char_code;
		cmd.eow   = in_ch.end_of_write;
		// saturate move target onto the screen
		cmd.col   = (32'(in_ch.col) < tcce_pkg::COLS) ?
			tcce_pkg::col_t'(in_ch.col) : tcce_pkg::LAST_COL;
		cmd.row   = (32'(in_ch.row) < tcce_pkg::ROWS) ?
			tcce_pkg::row_t'(in_ch.row) : tcce_pkg::LAST_ROW;
		cmd.rd_ok = (32'(in_ch.cell_index) < tcce_pkg::CELLS);
		cmd.ridx  = tcce_pkg::pos_t'(in_ch.cell_index);
		unique case (in_ch.opcode)
			tcce_pkg::OP_WRITE: begin
				unique case (in_ch.char_code)
					tcce_pkg::CH_BACKSPACE: cmd.kind = tcce_pkg::K_BS;
					tcce_pkg::CH_NEWLINE:   cmd.kind = tcce_pkg::K_NL;
					tcce_pkg::CH_TAB:       cmd.kind = tcce_pkg::K_TAB;
					default:                cmd.kind = tcce_pkg::K_PRINT;
				endcase
			end
			tcce_pkg::OP_CLEAR: cmd.kind = tcce_pkg::K_CLEAR;
			tcce_pkg::OP_MOVE:  cmd.kind = tcce_pkg::K_MOVE;
			tcce_pkg::OP_READ:  cmd.kind = tcce_pkg::K_READ;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/tcce_cmd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_cmd_queue
// Short show-ahead FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
module tcce_cmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tcce_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output tcce_pkg::cmd_t   head_cmd,
	output logic             full,
	output logic             empty
);

	tcce_pkg::cmd_t              entry_q [tcce_pkg::QUEUE_DEPTH];
	logic [tcce_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tcce_pkg::QPTR_W-1:0] rd_ptr_q;
	tcce_pkg::qcnt_t             count_q;

	assign full     = (count_q == tcce_pkg::QCNT_FULL);
	assign empty    = (count_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + tcce_pkg::qcnt_t'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tcce_pkg::qcnt_t'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/tcce_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_back
// Executes commands against the cell store: cursor, scroll ring, fills, reads.
// ----------------------------------------------------------------------------
module tcce_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcce_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  tcce_pkg::cmd_t                     cmd,
	input  logic                               q_empty,
	output logic                               pop,
	output logic                               init_busy,
	tcce_out_if.source                         out_ch
);

	typedef enum logic [1:0] {
		S_FILL,
		S_IDLE,
		S_TAB,
		S_RESP
	} state_t;

	state_t               state_q;
	tcce_pkg::col_t       cur_col_q;
	tcce_pkg::row_t       cur_row_q;
	tcce_pkg::pos_t       cur_pos_q;
	tcce_pkg::pos_t       shown_q;
	tcce_pkg::pos_t       base_off_q;
	tcce_pkg::pos_t       fill_addr_q;
	tcce_pkg::pos_t       fill_end_q;
	tcce_pkg::cell_t      fill_cell_q;
	logic                 init_q;
	logic                 upd_shown_q;
	logic                 rd_hit_q;
	tcce_pkg::color_t     fg_q;
	tcce_pkg::color_t     bg_q;
	logic                 out_vld_q;
	logic [tcce_pkg::IN_COL_W-1:0] out_col_q;
	logic [tcce_pkg::IN_ROW_W-1:0] out_row_q;
	logic [tcce_pkg::IDX_W-1:0]    out_pos_q;
	tcce_pkg::cell_t      out_cell_q;

	tcce_pkg::cell_t      mem [tcce_pkg::CELLS];
	tcce_pkg::cell_t      mem_rd_q;

	tcce_pkg::cell_t      blank_cell;
	logic                 last_col;
	logic                 last_row;
	tcce_pkg::row_t       nl_row;
	tcce_pkg::pos_t       nl_pos;
	tcce_pkg::col_t       adv_col;
	tcce_pkg::row_t       adv_row;
	tcce_pkg::pos_t       adv_pos;
	logic                 adv_scroll;
	tcce_pkg::col_t       bs_col;
	tcce_pkg::row_t       bs_row;
	tcce_pkg::pos_t       bs_pos;
	tcce_pkg::pos_t       move_pos;
	tcce_pkg::pos_t       base_adv;
	tcce_pkg::pos_x_t     base_sum;
	tcce_pkg::pos_t       cur_phys;
	tcce_pkg::pos_t       rd_phys;
	logic                 tab_step;
	logic                 put;
	tcce_pkg::char_t      put_char;
	logic                 mem_we;
	tcce_pkg::pos_t       mem_waddr;
	tcce_pkg::cell_t      mem_wdata;
	logic                 mem_re;
	logic                 slot_free;

	// logical position -> physical address in the row ring
	function automatic tcce_pkg::pos_t to_phys(tcce_pkg::pos_t p, tcce_pkg::pos_t base);
		tcce_pkg::pos_x_t s;
		s = {1'b0, p} + {1'b0, base};
		if (s >= tcce_pkg::CELLS_X) begin
			s = s - tcce_pkg::CELLS_X;
		end
		return tcce_pkg::pos_t'(s);
	endfunction

	assign init_busy = init_q;
	assign slot_free = !out_vld_q || out_ch.ready;

	assign out_ch.valid         = out_vld_q;
	assign out_ch.cursor_col    = out_col_q;
	assign out_ch.cursor_row    = out_row_q;
	assign out_ch.hw_cursor_pos = out_pos_q;
	assign out_ch.read_cell     = out_cell_q;

	always_comb begin
		blank_cell = {bg_q, fg_q, tcce_pkg::CH_SPACE};
		last_col   = (cur_col_q == tcce_pkg::LAST_COL);
		last_row   = (cur_row_q == tcce_pkg::LAST_ROW);

		// newline
		nl_row = last_row ? cur_row_q : cur_row_q + tcce_pkg::row_t'(1);
		nl_pos = last_row ? tcce_pkg::LAST_ROW_POS :
			cur_pos_q - tcce_pkg::pos_t'(cur_col_q) + tcce_pkg::pos_t'(tcce_pkg::COLS);

		// advance after a cell write
		adv_col    = last_col ? '0 : cur_col_q + tcce_pkg::col_t'(1);
		adv_row    = last_col ? nl_row : cur_row_q;
		adv_pos    = last_col ? nl_pos : cur_pos_q + tcce_pkg::pos_t'(1);
		adv_scroll = last_col && last_row;

		// backspace; top-left corner holds
		bs_col = cur_col_q;
		bs_row = cur_row_q;
		bs_pos = cur_pos_q;
		if (cur_col_q != '0) begin
			bs_col = cur_col_q - tcce_pkg::col_t'(1);
			bs_pos = cur_pos_q - tcce_pkg::pos_t'(1);
		end else if (cur_row_q != '0) begin
			bs_col = tcce_pkg::LAST_COL;
			bs_row = cur_row_q - tcce_pkg::row_t'(1);
			bs_pos = cur_pos_q - tcce_pkg::pos_t'(1);
		end

		move_pos = tcce_pkg::pos_t'(cmd.row * tcce_pkg::COLS) + tcce_pkg::pos_t'(cmd.col);

		base_sum = {1'b0, base_off_q} + tcce_pkg::pos_x_t'(tcce_pkg::COLS);
		base_adv = (base_sum >= tcce_pkg::CELLS_X) ? '0 : tcce_pkg::pos_t'(base_sum);

		cur_phys = to_phys(cur_pos_q, base_off_q);
		rd_phys  = to_phys(cmd.ridx, base_off_q);

		pop      = (state_q == S_IDLE) && !q_empty;
		tab_step = (state_q == S_TAB) || (pop && cmd.kind == tcce_pkg::K_TAB);
		put      = tab_step || (pop && cmd.kind == tcce_pkg::K_PRINT);
		put_char = (state_q == S_IDLE && cmd.kind == tcce_pkg::K_PRINT) ?
			cmd.ch : tcce_pkg::CH_SPACE;

		mem_we    = 1'b0;
		mem_waddr = cur_phys;
		mem_wdata = {bg_q, fg_q, put_char};
		if (state_q == S_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = fill_addr_q;
			mem_wdata = fill_cell_q;
		end else if (put) begin
			mem_we = 1'b1;
		end
		mem_re = pop && cmd.kind == tcce_pkg::K_READ && cmd.rd_ok;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= mem[rd_phys];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			cur_pos_q   <= '0;
			shown_q     <= '0;
			base_off_q  <= '0;
			fill_addr_q <= '0;
			fill_end_q  <= tcce_pkg::pos_t'(tcce_pkg::CELLS - 1);
			fill_cell_q <= tcce_pkg::RESET_CELL;
			init_q      <= 1'b1;
			upd_shown_q <= 1'b0;
			rd_hit_q    <= 1'b0;
			fg_q        <= tcce_pkg::RESET_FG;
			bg_q        <= tcce_pkg::RESET_BG;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == tcce_pkg::REG_FG) begin
					fg_q <= cfg_data;
				end
				if (cfg_index == tcce_pkg::REG_BG) begin
					bg_q <= cfg_data;
				end
			end

			// hold the result beat until the sink takes it
			if (state_q == S_RESP && slot_free) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end

			// drop a row into the ring: reuse the old top row as the new bottom
			if (put && adv_scroll ||
				pop && cmd.kind == tcce_pkg::K_NL && last_row) begin
				base_off_q  <= base_adv;
				fill_addr_q <= base_off_q;
				fill_end_q  <= base_off_q + tcce_pkg::pos_t'(tcce_pkg::COLS - 1);
				fill_cell_q <= blank_cell;
			end

			if (put) begin
				cur_col_q <= adv_col;
				cur_row_q <= adv_row;
				cur_pos_q <= adv_pos;
			end

			unique case (state_q)
				S_FILL: begin
					fill_addr_q <= fill_addr_q + tcce_pkg::pos_t'(1);
					if (fill_addr_q == fill_end_q) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_RESP;
					end
				end
				S_IDLE: begin
					if (pop) begin
						unique case (cmd.kind)
							tcce_pkg::K_PRINT: begin
								upd_shown_q <= cmd.eow;
								rd_hit_q    <= 1'b0;
								state_q     <= adv_scroll ? S_FILL : S_RESP;
							end
							tcce_pkg::K_TAB: begin
								upd_shown_q <= cmd.eow;
								rd_hit_q    <= 1'b0;
								if (adv_scroll) begin
									state_q <= S_FILL;
								end else if (tcce_pkg::TAB_HIT[adv_col]) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_TAB;
								end
							end
							tcce_pkg::K_BS: begin
								upd_shown_q <= cmd.eow;
								rd_hit_q    <= 1'b0;
								cur_col_q   <= bs_col;
								cur_row_q   <= bs_row;
								cur_pos_q   <= bs_pos;
								state_q     <= S_RESP;
							end
							tcce_pkg::K_NL: begin
								upd_shown_q <= cmd.eow;
								rd_hit_q    <= 1'b0;
								cur_col_q   <= '0;
								cur_row_q   <= nl_row;
								cur_pos_q   <= nl_pos;
								state_q     <= last_row ? S_FILL : S_RESP;
							end
							tcce_pkg::K_CLEAR: begin
								upd_shown_q <= 1'b0;
								rd_hit_q    <= 1'b0;
								cur_col_q   <= '0;
								cur_row_q   <= '0;
								cur_pos_q   <= '0;
								base_off_q  <= '0;
								fill_addr_q <= '0;
								fill_end_q  <= tcce_pkg::pos_t'(tcce_pkg::CELLS - 1);
								fill_cell_q <= blank_cell;
								state_q     <= S_FILL;
							end
							tcce_pkg::K_MOVE: begin
								upd_shown_q <= 1'b1;
								rd_hit_q    <= 1'b0;
								cur_col_q   <= cmd.col;
								cur_row_q   <= cmd.row;
								cur_pos_q   <= move_pos;
								state_q     <= S_RESP;
							end
							tcce_pkg::K_READ: begin
								upd_shown_q <= 1'b0;
								rd_hit_q    <= cmd.rd_ok;
								state_q     <= S_RESP;
							end
							default: begin
								upd_shown_q <= 1'b0;
								rd_hit_q    <= 1'b0;
								state_q     <= S_RESP;
							end
						endcase
					end
				end
				S_TAB: begin
					if (adv_scroll) begin
						state_q <= S_FILL;
					end else if (tcce_pkg::TAB_HIT[adv_col]) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (slot_free) begin
						out_col_q  <= tcce_pkg::IN_COL_W'(cur_col_q);
						out_row_q  <= tcce_pkg::IN_ROW_W'(cur_row_q);
						out_pos_q  <= tcce_pkg::IDX_W'(upd_shown_q ? cur_pos_q : shown_q);
						out_cell_q <= rd_hit_q ? mem_rd_q : '0;
						if (upd_shown_q) begin
							shown_q <= cur_pos_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/text_console_cell_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_engine_unit
// 80x25 text console: cell store, cursor, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// Every command beat gives exactly one result beat. For a printable character,
// backspace, newline without scroll, cursor move and cell read the execution
// unit first updates the cursor and touches the single-port cell store, then
// loads the result register once the result slot is free. A tab writes one
// space per step up to the next tab stop. Scrolling rotates a row ring instead
// of copying, so it adds the blanking of one row of COLS (80) cells.
// Clear screen rewrites the whole store at one cell a cycle. After reset the
// store is initialized the same way, and no command beat is taken until that
// pass ends; register writes are taken throughout. A two deep command queue
// lets beats arrive while the store is busy.
// ----------------------------------------------------------------------------
module text_console_cell_engine_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcce_pkg::CFG_DATA_W-1:0]    cfg_data,
	tcce_in_if.sink                            in_ch,
	tcce_out_if.source                         out_ch
);

	tcce_pkg::cmd_t push_cmd;
	tcce_pkg::cmd_t head_cmd;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	logic           init_busy;

	tcce_front u_front (
		.in_ch     (in_ch),
		.q_full    (q_full),
		.init_busy (init_busy),
		.push      (push),
		.cmd       (push_cmd)
	);

	tcce_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	tcce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (head_cmd),
		.q_empty   (q_empty),
		.pop       (pop),
		.init_busy (init_busy),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire
